>>> hdl/jfpr_pkg.sv
// ----------------------------------------------------------------------------
// jfpr_pkg
// Shared constants, payload types and register indexes of the four-point
// Jacobi relaxation block.
// ----------------------------------------------------------------------------
package jfpr_pkg;

  localparam int unsigned GRID_MAX_DEF    = 1024;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned CELL_W     = 32;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned GSZ_W      = 11;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned GRID_MIN   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

  localparam logic [GSZ_W-1:0] GSZ_RESET = 11'd514;
  localparam logic [RES_W-1:0] THR_RESET = 32'd1;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
  } in_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] new_value;
    logic [RES_W-1:0]  residual;
    logic [RES_W-1:0]  max_residual;
    logic              frame_last;
    logic              converged;
  } out_req_t;

  typedef struct packed {
    logic has_above;
    logic has_cur;
    logic interior;
    logic last_cell;
  } flags_t;

endpackage

>>> hdl/jfpr_stream_if.sv
// ----------------------------------------------------------------------------
// jfpr_stream_if
// Valid/ready request channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface jfpr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/jfpr_ram.sv
// ----------------------------------------------------------------------------
// jfpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module jfpr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> hdl/jfpr_window.sv
// ----------------------------------------------------------------------------
// jfpr_window
// Raster position counters and the two line buffers. Each accepted cell below
// the first row gathers the four neighbors and the center value of the cell above it into the first stage.
// ----------------------------------------------------------------------------
module jfpr_window #(
  parameter int unsigned GRID_MAX    = jfpr_pkg::GRID_MAX_DEF,
  parameter int unsigned VALUE_WIDTH = jfpr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [jfpr_pkg::GSZ_W-1:0] grid_size_i,
  input  logic                       restart_i,
  input  logic                       in_valid_i,
  input  logic [VALUE_WIDTH-1:0]     in_value_i,
  output logic                       in_ready_o,
  output logic                       p1_valid_o,
  input  logic                       p1_ready_i,
  output logic [VALUE_WIDTH-1:0]     p1_up_o,
  output logic [VALUE_WIDTH-1:0]     p1_down_o,
  output logic [VALUE_WIDTH-1:0]     p1_left_o,
  output logic [VALUE_WIDTH-1:0]     p1_right_o,
  output logic [VALUE_WIDTH-1:0]     p1_center_o,
  output jfpr_pkg::flags_t           p1_flags_o
);
  localparam int unsigned COL_W = $clog2(GRID_MAX);
  localparam int unsigned NW    = $clog2(GRID_MAX + 1);
  localparam int unsigned CW    = ((NW > jfpr_pkg::GSZ_W) ? NW : jfpr_pkg::GSZ_W) + 1;

  logic [COL_W-1:0]       col_q, col_d, row_q, row_d;
  logic [CW-1:0]          gsz_ext, n_use, r_ext, c_ext;
  logic                   accept, last_row, last_col;
  logic [VALUE_WIDTH-1:0] up, right, center;
  logic [VALUE_WIDTH-1:0] center_q, left_q, row_first_q;
  logic                   p1_valid_q;
  logic [VALUE_WIDTH-1:0] p1_up_q, p1_down_q, p1_left_q, p1_right_q, p1_center_q;
  jfpr_pkg::flags_t       flags, p1_flags_q;

  assign gsz_ext = CW'(grid_size_i);
  always_comb begin
    if (gsz_ext < CW'(jfpr_pkg::GRID_MIN)) begin
      n_use = CW'(jfpr_pkg::GRID_MIN);
    end else if (gsz_ext > CW'(GRID_MAX)) begin
      n_use = CW'(GRID_MAX);
    end else begin
      n_use = gsz_ext;
    end
  end

  assign r_ext    = CW'(row_q);
  assign c_ext    = CW'(col_q);
  assign last_row = (r_ext + CW'(1)) >= n_use;
  assign last_col = (c_ext + CW'(1)) >= n_use;

  assign flags.has_above = (row_q != '0);
  assign flags.has_cur   = last_row;
  assign flags.interior  = (r_ext >= CW'(2)) && (col_q != '0) && ((c_ext + CW'(2)) <= n_use);
  assign flags.last_cell = last_row && last_col;

  assign in_ready_o = !p1_valid_q || p1_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + COL_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // The row above is read at the column of the next cell, the current row
  // one column ahead of it; the first column of a row comes from a register.
  jfpr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(GRID_MAX)) u_older (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (center),
    .raddr_i (col_d),
    .rdata_o (up)
  );

  jfpr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(GRID_MAX)) u_newer (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (in_value_i),
    .raddr_i (col_d + COL_W'(1)),
    .rdata_o (right)
  );

  assign center = (col_q == '0) ? row_first_q : center_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      p1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_ready_o) begin
        p1_valid_q <= accept && (flags.has_above || flags.has_cur);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      center_q    <= right;
      left_q      <= center;
      if (col_q == '0) begin
        row_first_q <= in_value_i;
      end
      p1_up_q     <= up;
      p1_down_q   <= in_value_i;
      p1_left_q   <= left_q;
      p1_right_q  <= right;
      p1_center_q <= center;
      p1_flags_q  <= flags;
    end
  end

  assign p1_valid_o  = p1_valid_q;
  assign p1_up_o     = p1_up_q;
  assign p1_down_o   = p1_down_q;
  assign p1_left_o   = p1_left_q;
  assign p1_right_o  = p1_right_q;
  assign p1_center_o = p1_center_q;
  assign p1_flags_o  = p1_flags_q;
endmodule

>>> hdl/jfpr_update.sv
// ----------------------------------------------------------------------------
// jfpr_update
// Stencil average, residual and result emission. A cell on the last row
// yields two results, which leave one after the other.
// ----------------------------------------------------------------------------
module jfpr_update #(
  parameter int unsigned VALUE_WIDTH = jfpr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [jfpr_pkg::RES_W-1:0] threshold_i,
  input  logic                       restart_i,
  input  logic                       p1_valid_i,
  output logic                       p1_ready_o,
  input  logic [VALUE_WIDTH-1:0]     p1_up_i,
  input  logic [VALUE_WIDTH-1:0]     p1_down_i,
  input  logic [VALUE_WIDTH-1:0]     p1_left_i,
  input  logic [VALUE_WIDTH-1:0]     p1_right_i,
  input  logic [VALUE_WIDTH-1:0]     p1_center_i,
  input  jfpr_pkg::flags_t           p1_flags_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output jfpr_pkg::out_req_t         out_data_o
);
  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned RES_W = jfpr_pkg::RES_W;
  localparam int unsigned CELL_W = jfpr_pkg::CELL_W;

  logic [VW+1:0]      sum;
  logic [VW-1:0]      value;
  logic               p2_valid_q, p3_valid_q, p3_second_q, out_valid_q;
  logic [VW-1:0]      p2_value_q, p2_center_q, p2_down_q;
  jfpr_pkg::flags_t   p2_flags_q, p3_flags_q;
  logic [VW:0]        diff;
  logic [VW-1:0]      absd;
  logic [RES_W-1:0]   sat;
  logic [VW-1:0]      p3_value_q, p3_down_q;
  logic [RES_W-1:0]   p3_res_q;
  logic               out_free, emit_above, emit, p3_done, p3_free, p2_free;
  logic [VW-1:0]      sel_value;
  logic [RES_W-1:0]   sel_res, max_q, max_new;
  logic               sel_last;
  logic [CELL_W-1:0]  sel_cell;
  jfpr_pkg::out_req_t out_q;

  assign sum = {{2{p1_up_i[VW-1]}}, p1_up_i} + {{2{p1_down_i[VW-1]}}, p1_down_i}
             + {{2{p1_left_i[VW-1]}}, p1_left_i} + {{2{p1_right_i[VW-1]}}, p1_right_i};
  assign value = p1_flags_i.interior ? sum[VW+1:2] : p1_center_i;

  assign diff = {p2_center_q[VW-1], p2_center_q} - {p2_value_q[VW-1], p2_value_q};
  assign absd = diff[VW] ? VW'(-diff) : diff[VW-1:0];

  if (VW > RES_W) begin : g_sat
    assign sat = (|absd[VW-1:RES_W]) ? '1 : absd[RES_W-1:0];
  end else begin : g_nosat
    assign sat = RES_W'(absd);
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit_above = p3_flags_q.has_above && !p3_second_q;
  assign emit       = p3_valid_q && out_free;
  assign p3_done    = emit && !(emit_above && p3_flags_q.has_cur);
  assign p3_free    = !p3_valid_q || p3_done;
  assign p2_free    = !p2_valid_q || p3_free;
  assign p1_ready_o = p2_free;

  assign sel_value = emit_above ? p3_value_q : p3_down_q;
  assign sel_res   = emit_above ? p3_res_q : '0;
  assign sel_last  = !emit_above && p3_flags_q.last_cell;
  assign max_new   = (sel_res > max_q) ? sel_res : max_q;

  if (VW >= CELL_W) begin : g_cut
    assign sel_cell = sel_value[CELL_W-1:0];
  end else begin : g_ext
    assign sel_cell = CELL_W'(sel_value);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q  <= 1'b0;
      p3_valid_q  <= 1'b0;
      p3_second_q <= 1'b0;
      out_valid_q <= 1'b0;
      max_q       <= '0;
    end else begin
      if (p2_free) begin
        p2_valid_q <= p1_valid_i;
      end
      if (p3_free) begin
        p3_valid_q <= p2_valid_q;
      end
      if (p3_done) begin
        p3_second_q <= 1'b0;
      end else if (emit) begin
        p3_second_q <= 1'b1;
      end
      out_valid_q <= emit || (out_valid_q && !out_ready_i);
      if (restart_i) begin
        max_q <= '0;
      end else if (emit) begin
        max_q <= sel_last ? '0 : max_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_free && p1_valid_i) begin
      p2_value_q  <= value;
      p2_center_q <= p1_center_i;
      p2_down_q   <= p1_down_i;
      p2_flags_q  <= p1_flags_i;
    end
    if (p3_free && p2_valid_q) begin
      p3_value_q <= p2_value_q;
      p3_down_q  <= p2_down_q;
      p3_res_q   <= p2_flags_q.interior ? sat : '0;
      p3_flags_q <= p2_flags_q;
    end
    if (emit) begin
      out_q.new_value    <= sel_cell;
      out_q.residual     <= sel_res;
      out_q.max_residual <= max_new;
      out_q.frame_last   <= sel_last;
      out_q.converged    <= sel_last && (max_new < threshold_i);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

>>> hdl/jacobi_four_point_relax.sv
// ----------------------------------------------------------------------------
// jacobi_four_point_relax
// One streamed four-point Jacobi sweep over a square Q16.16 grid.
// ----------------------------------------------------------------------------
// A result passes the p1, p2, p3 and output registers after the cell that
// completes it; on the last row the arriving cell's own result follows that one.
// One cell per cycle while the output is not stalled; on the last row each
// cell carries two results, so the output port sets the pace there.
// Reset clears the position counters, the running maximum and all valids,
// and loads grid_size with 514 and converge_threshold with 1; the line
// buffers are not cleared and need no clearing pass.
module jacobi_four_point_relax #(
  parameter int unsigned GRID_MAX    = jfpr_pkg::GRID_MAX_DEF,
  parameter int unsigned VALUE_WIDTH = jfpr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  jfpr_stream_if.sink                     in_req,
  jfpr_stream_if.source                   out_req,
  input  logic                            cfg_we_i,
  input  logic [jfpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jfpr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  localparam int unsigned CELL_W = jfpr_pkg::CELL_W;

  logic [jfpr_pkg::GSZ_W-1:0] grid_size_q;
  logic [jfpr_pkg::RES_W-1:0] threshold_q;
  logic                       restart;
  logic [VALUE_WIDTH-1:0]     in_value;
  logic                       p1_valid, p1_ready;
  logic [VALUE_WIDTH-1:0]     p1_up, p1_down, p1_left, p1_right, p1_center;
  jfpr_pkg::flags_t           p1_flags;

  assign restart = cfg_we_i && (cfg_idx_i == jfpr_pkg::CFG_GRID_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= jfpr_pkg::GSZ_RESET;
      threshold_q <= jfpr_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jfpr_pkg::CFG_GRID_SIZE: grid_size_q <= cfg_data_i[jfpr_pkg::GSZ_W-1:0];
        jfpr_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i[jfpr_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  if (VALUE_WIDTH <= CELL_W) begin : g_in_cut
    assign in_value = in_req.data.cell_value[VALUE_WIDTH-1:0];
  end else begin : g_in_ext
    assign in_value = {{(VALUE_WIDTH - CELL_W){in_req.data.cell_value[CELL_W-1]}},
                       in_req.data.cell_value};
  end

  jfpr_window #(.GRID_MAX(GRID_MAX), .VALUE_WIDTH(VALUE_WIDTH)) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_size_i (grid_size_q),
    .restart_i   (restart),
    .in_valid_i  (in_req.valid),
    .in_value_i  (in_value),
    .in_ready_o  (in_req.ready),
    .p1_valid_o  (p1_valid),
    .p1_ready_i  (p1_ready),
    .p1_up_o     (p1_up),
    .p1_down_o   (p1_down),
    .p1_left_o   (p1_left),
    .p1_right_o  (p1_right),
    .p1_center_o (p1_center),
    .p1_flags_o  (p1_flags)
  );

  jfpr_update #(.VALUE_WIDTH(VALUE_WIDTH)) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (threshold_q),
    .restart_i   (restart),
    .p1_valid_i  (p1_valid),
    .p1_ready_o  (p1_ready),
    .p1_up_i     (p1_up),
    .p1_down_i   (p1_down),
    .p1_left_i   (p1_left),
    .p1_right_i  (p1_right),
    .p1_center_i (p1_center),
    .p1_flags_i  (p1_flags),
    .out_valid_o (out_req.valid),
    .out_ready_i (out_req.ready),
    .out_data_o  (out_req.data)
  );
endmodule

>>> hdl/jfpr_checker.sv
// ----------------------------------------------------------------------------
// jfpr_checker
// Port-level checks of the relaxation block's result stream.
// ----------------------------------------------------------------------------
module jfpr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [jfpr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input jfpr_pkg::out_req_t             out_data_i
);
  logic                       have_prev_q;
  logic [jfpr_pkg::RES_W-1:0] prev_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_max_q  <= '0;
    end else if (cfg_we_i && (cfg_idx_i == jfpr_pkg::CFG_GRID_SIZE)) begin
      have_prev_q <= 1'b0;
    end else if (out_valid_i && out_ready_i) begin
      have_prev_q <= !out_data_i.frame_last;
      prev_max_q  <= out_data_i.max_residual;
    end
  end

  a_conv_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.converged |-> out_data_i.frame_last)
    else $error("converged flag set on a result that does not end the sweep");

  a_res_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.residual <= out_data_i.max_residual)
    else $error("residual exceeds the running maximum");

  a_max_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && have_prev_q |-> out_data_i.max_residual >= prev_max_q)
    else $error("running maximum decreased within a sweep");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result request changed");
endmodule

bind jacobi_four_point_relax jfpr_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .out_valid_i (out_req.valid),
  .out_ready_i (out_req.ready),
  .out_data_i  (out_req.data)
);
